>>> hdl/rcs_pkg.sv
// Package with sizes, request codes and shared types of the row/column swap cell map.
`timescale 1ns / 1ps
`default_nettype none
package rcs_pkg;

  // Grid size.
  localparam int ROWS = 1024;
  localparam int COLS = 4096;

  // Map index widths, derived from the grid size.
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int MAP_W    = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int INIT_LEN = (ROWS > COLS) ? ROWS : COLS;
  localparam int CNT_W    = (INIT_LEN > 1) ? $clog2(INIT_LEN) : 1;

  // Fixed field widths of the channels.
  localparam int REQ_W  = 2;
  localparam int IDX_W  = 13;
  localparam int CELL_W = 23;
  localparam int ROWP_W = 11;
  localparam int COLP_W = 13;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_SWAP_ROW = 2'd0,
    REQ_SWAP_COL = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_LOCATE   = 2'd3
  } req_e;

  // Result codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_ERR  = 1'b1;
  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_LOCATE = 1'b1;

  // Access to one row map memory.
  typedef struct packed {
    logic             re;
    logic [ROW_W-1:0] raddr;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;
  } row_cmd_t;

  // Access to one column map memory.
  typedef struct packed {
    logic             re;
    logic [COL_W-1:0] raddr;
    logic             we;
    logic [COL_W-1:0] waddr;
    logic [COL_W-1:0] wdata;
  } col_cmd_t;

  // One result item.
  typedef struct packed {
    logic              status;
    logic              result_kind;
    logic [CELL_W-1:0] cell_value;
    logic [ROWP_W-1:0] row_position;
    logic [COLP_W-1:0] col_position;
  } rsp_t;

endpackage
`default_nettype wire

>>> hdl/rcs_req_if.sv
// Request channel interface of the row/column swap cell map.
`timescale 1ns / 1ps
`default_nettype none
interface rcs_req_if import rcs_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  index_a;
  logic [IDX_W-1:0]  index_b;
  logic [CELL_W-1:0] cell_number;

  modport source (
    output valid, req_type, index_a, index_b, cell_number,
    input  ready
  );

  modport sink (
    input  valid, req_type, index_a, index_b, cell_number,
    output ready
  );

endinterface
`default_nettype wire

>>> hdl/rcs_rsp_if.sv
// Result channel interface of the row/column swap cell map.
`timescale 1ns / 1ps
`default_nettype none
interface rcs_rsp_if import rcs_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              status;
  logic              result_kind;
  logic [CELL_W-1:0] cell_value;
  logic [ROWP_W-1:0] row_position;
  logic [COLP_W-1:0] col_position;

  modport source (
    output valid, status, result_kind, cell_value, row_position, col_position,
    input  ready
  );

  modport sink (
    input  valid, status, result_kind, cell_value, row_position, col_position,
    output ready
  );

endinterface
`default_nettype wire

>>> hdl/rcs_ram.sv
// Generic single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rcs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/rcs_seq.sv
// Request sequencer: clearing pass, range checks, map reads, swaps and result forming.
`timescale 1ns / 1ps
`default_nettype none
module rcs_seq import rcs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  rcs_req_if.sink               req_i,
  output row_cmd_t              row_src_cmd_o,
  output row_cmd_t              row_plc_cmd_o,
  output col_cmd_t              col_src_cmd_o,
  output col_cmd_t              col_plc_cmd_o,
  input  wire logic [ROW_W-1:0] row_src_rdata_i,
  input  wire logic [ROW_W-1:0] row_plc_rdata_i,
  input  wire logic [COL_W-1:0] col_src_rdata_i,
  input  wire logic [COL_W-1:0] col_plc_rdata_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output rsp_t                  res_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWAP_RD,
    ST_SWAP_WR1,
    ST_SWAP_WR2,
    ST_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  req_e              kind_q, kind_d;
  logic              err_q, err_d;
  logic [MAP_W-1:0]  a0_q, a0_d;
  logic [MAP_W-1:0]  b0_q, b0_d;
  logic [MAP_W-1:0]  sa_q, sa_d;

  req_e              req_kind;
  logic              accept;
  logic              req_err;
  logic              a_row_ok, b_row_ok, a_col_ok, b_col_ok, n_ok;
  logic [IDX_W-1:0]  a_dec, b_dec;
  logic [MAP_W-1:0]  a0, b0;
  logic [CELL_W-1:0] n0;
  logic              row_sel;
  logic [MAP_W-1:0]  src_rdata;

  // Decode and range check of the offered item.
  assign req_kind = req_e'(req_i.req_type);
  assign accept   = req_i.valid && req_i.ready;
  assign a_dec    = req_i.index_a - IDX_W'(1);
  assign b_dec    = req_i.index_b - IDX_W'(1);
  assign a0       = MAP_W'(a_dec);
  assign b0       = MAP_W'(b_dec);
  assign n0       = req_i.cell_number - CELL_W'(1);
  assign a_row_ok = (req_i.index_a != '0) && (32'(req_i.index_a) <= ROWS);
  assign b_row_ok = (req_i.index_b != '0) && (32'(req_i.index_b) <= ROWS);
  assign a_col_ok = (req_i.index_a != '0) && (32'(req_i.index_a) <= COLS);
  assign b_col_ok = (req_i.index_b != '0) && (32'(req_i.index_b) <= COLS);
  assign n_ok     = (req_i.cell_number != '0) &&
                    (64'(req_i.cell_number) <= 64'(ROWS) * 64'(COLS));

  always_comb begin
    unique case (req_kind)
      REQ_SWAP_ROW: req_err = !(a_row_ok && b_row_ok);
      REQ_SWAP_COL: req_err = !(a_col_ok && b_col_ok);
      REQ_QUERY:    req_err = !(a_row_ok && b_col_ok);
      REQ_LOCATE:   req_err = !n_ok;
      default:      req_err = 1'b1;
    endcase
  end

  // Source entry read back during a swap, from the map that the swap touches.
  assign row_sel   = (kind_q == REQ_SWAP_ROW);
  assign src_rdata = row_sel ? MAP_W'(row_src_rdata_i) : MAP_W'(col_src_rdata_i);

  // Next state and memory accesses.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    kind_d        = kind_q;
    err_d         = err_q;
    a0_d          = a0_q;
    b0_d          = b0_q;
    sa_d          = sa_q;
    row_src_cmd_o = '0;
    row_plc_cmd_o = '0;
    col_src_cmd_o = '0;
    col_plc_cmd_o = '0;
    unique case (state_q)
      ST_INIT: begin
        // Clearing pass: every map entry gets its own index.
        row_src_cmd_o.we    = (32'(cnt_q) < ROWS);
        row_src_cmd_o.waddr = ROW_W'(cnt_q);
        row_src_cmd_o.wdata = ROW_W'(cnt_q);
        row_plc_cmd_o.we    = (32'(cnt_q) < ROWS);
        row_plc_cmd_o.waddr = ROW_W'(cnt_q);
        row_plc_cmd_o.wdata = ROW_W'(cnt_q);
        col_src_cmd_o.we    = (32'(cnt_q) < COLS);
        col_src_cmd_o.waddr = COL_W'(cnt_q);
        col_src_cmd_o.wdata = COL_W'(cnt_q);
        col_plc_cmd_o.we    = (32'(cnt_q) < COLS);
        col_plc_cmd_o.waddr = COL_W'(cnt_q);
        col_plc_cmd_o.wdata = COL_W'(cnt_q);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(INIT_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Reads for the accepted item go out in the same cycle.
        row_src_cmd_o.raddr = ROW_W'(a0);
        col_src_cmd_o.raddr = (req_kind == REQ_SWAP_COL) ? COL_W'(a0) : COL_W'(b0);
        row_plc_cmd_o.raddr = ROW_W'(n0 / COLS);
        col_plc_cmd_o.raddr = COL_W'(n0 % COLS);
        if (accept) begin
          row_src_cmd_o.re = 1'b1;
          row_plc_cmd_o.re = 1'b1;
          col_src_cmd_o.re = 1'b1;
          col_plc_cmd_o.re = 1'b1;
          kind_d = req_kind;
          err_d  = req_err;
          a0_d   = a0;
          b0_d   = b0;
          if (!req_err && (req_kind == REQ_SWAP_ROW || req_kind == REQ_SWAP_COL)) begin
            state_d = ST_SWAP_RD;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SWAP_RD: begin
        // Keep the source of the first index, fetch the source of the second.
        sa_d = src_rdata;
        if (row_sel) begin
          row_src_cmd_o.re    = 1'b1;
          row_src_cmd_o.raddr = ROW_W'(b0_q);
        end else begin
          col_src_cmd_o.re    = 1'b1;
          col_src_cmd_o.raddr = COL_W'(b0_q);
        end
        state_d = ST_SWAP_WR1;
      end
      ST_SWAP_WR1: begin
        // The first index takes the second source; that source now sits at the first index.
        if (row_sel) begin
          row_src_cmd_o.we    = 1'b1;
          row_src_cmd_o.waddr = ROW_W'(a0_q);
          row_src_cmd_o.wdata = ROW_W'(src_rdata);
          row_plc_cmd_o.we    = 1'b1;
          row_plc_cmd_o.waddr = ROW_W'(src_rdata);
          row_plc_cmd_o.wdata = ROW_W'(a0_q);
        end else begin
          col_src_cmd_o.we    = 1'b1;
          col_src_cmd_o.waddr = COL_W'(a0_q);
          col_src_cmd_o.wdata = COL_W'(src_rdata);
          col_plc_cmd_o.we    = 1'b1;
          col_plc_cmd_o.waddr = COL_W'(src_rdata);
          col_plc_cmd_o.wdata = COL_W'(a0_q);
        end
        state_d = ST_SWAP_WR2;
      end
      ST_SWAP_WR2: begin
        // The second index takes the first source, and its inverse entry follows.
        if (row_sel) begin
          row_src_cmd_o.we    = 1'b1;
          row_src_cmd_o.waddr = ROW_W'(b0_q);
          row_src_cmd_o.wdata = ROW_W'(sa_q);
          row_plc_cmd_o.we    = 1'b1;
          row_plc_cmd_o.waddr = ROW_W'(sa_q);
          row_plc_cmd_o.wdata = ROW_W'(b0_q);
        end else begin
          col_src_cmd_o.we    = 1'b1;
          col_src_cmd_o.waddr = COL_W'(b0_q);
          col_src_cmd_o.wdata = COL_W'(sa_q);
          col_plc_cmd_o.we    = 1'b1;
          col_plc_cmd_o.waddr = COL_W'(sa_q);
          col_plc_cmd_o.wdata = COL_W'(b0_q);
        end
        state_d = ST_IDLE;
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
        cnt_d   = '0;
      end
    endcase
  end

  // Result item, formed from the read data that the memories hold.
  always_comb begin
    res_o             = '0;
    res_o.status      = err_q ? STATUS_ERR : STATUS_OK;
    res_o.result_kind = (kind_q == REQ_LOCATE) ? KIND_LOCATE : KIND_QUERY;
    if (!err_q && kind_q == REQ_QUERY) begin
      res_o.cell_value = CELL_W'(row_src_rdata_i) * CELL_W'(COLS)
                       + CELL_W'(col_src_rdata_i) + CELL_W'(1);
    end
    if (!err_q && kind_q == REQ_LOCATE) begin
      res_o.row_position = ROWP_W'(row_plc_rdata_i) + ROWP_W'(1);
      res_o.col_position = COLP_W'(col_plc_rdata_i) + COLP_W'(1);
    end
  end

  assign res_valid_o = (state_q == ST_RESULT);
  assign req_i.ready = (state_q == ST_IDLE);

  // State and item registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    err_q  <= err_d;
    a0_q   <= a0_d;
    b0_q   <= b0_d;
    sa_q   <= sa_d;
  end

  // A valid swap gives no result while it runs.
  a_swap_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req_err && (req_kind == REQ_SWAP_ROW || req_kind == REQ_SWAP_COL))
    |=> !res_valid_o ##1 !res_valid_o ##1 !res_valid_o)
    else $error("Swap item produced a result.");

  // A forward map and its inverse are always written together.
  a_pair_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_src_cmd_o.we == row_plc_cmd_o.we) && (col_src_cmd_o.we == col_plc_cmd_o.we))
    else $error("Forward and inverse map writes out of step.");

  // A result waiting for the output register holds its value.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("Pending result changed.");

  // One item at a time: no accept right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("Item accepted while another is in work.");

endmodule
`default_nettype wire

>>> hdl/rcs_out_reg.sv
// One-entry output register between the sequencer and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module rcs_out_reg import rcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  output logic      res_ready_o,
  input  wire rsp_t res_i,
  rcs_rsp_if.source rsp_o
);

  logic valid_q;
  rsp_t data_q;

  // The slot takes a new item when it is empty or drains in this cycle.
  assign res_ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i && res_ready_o) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  // Drive the result channel.
  assign rsp_o.valid        = valid_q;
  assign rsp_o.status       = data_q.status;
  assign rsp_o.result_kind  = data_q.result_kind;
  assign rsp_o.cell_value   = data_q.cell_value;
  assign rsp_o.row_position = data_q.row_position;
  assign rsp_o.col_position = data_q.col_position;

endmodule
`default_nettype wire

>>> hdl/row_column_swap_cell_map.sv
// Top level of the row/column swap cell map: sequencer, four map memories, output register.
//
//   Channel  Dir  Modport  Moves
//   req_i    in   sink     swap rows, swap columns, query or locate request item
//   rsp_o    out  source   status, kind, cell value, row and column position item
//
// A row or column swap runs through accept with read of the first source entry, read of
// the second, then ST_SWAP_WR1 and ST_SWAP_WR2, each writing one forward and one inverse entry.
// A query, a locate or a rejected item runs through accept with reads, then hand-off of
// the result to the output register; an item is accepted while a result waits there.
// After reset a clearing pass loads every map entry with its own index; no item is accepted
// before it ends. A stalled result channel holds the sequencer in its result step once the
// output register is full.
`timescale 1ns / 1ps
`default_nettype none
module row_column_swap_cell_map import rcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rcs_req_if.sink   req_i,
  rcs_rsp_if.source rsp_o
);

  row_cmd_t         row_src_cmd, row_plc_cmd;
  col_cmd_t         col_src_cmd, col_plc_cmd;
  logic [ROW_W-1:0] row_src_rdata, row_plc_rdata;
  logic [COL_W-1:0] col_src_rdata, col_plc_rdata;
  logic             res_valid;
  logic             res_ready;
  rsp_t             res;

  // Request sequencing.
  rcs_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .row_src_cmd_o   (row_src_cmd),
    .row_plc_cmd_o   (row_plc_cmd),
    .col_src_cmd_o   (col_src_cmd),
    .col_plc_cmd_o   (col_plc_cmd),
    .row_src_rdata_i (row_src_rdata),
    .row_plc_rdata_i (row_plc_rdata),
    .col_src_rdata_i (col_src_rdata),
    .col_plc_rdata_i (col_plc_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // Row maps: original row at each current row, and its inverse.
  rcs_ram #(.DEPTH(ROWS), .WIDTH(ROW_W)) u_row_src (
    .clk_i   (clk_i),
    .we_i    (row_src_cmd.we),
    .waddr_i (row_src_cmd.waddr),
    .wdata_i (row_src_cmd.wdata),
    .re_i    (row_src_cmd.re),
    .raddr_i (row_src_cmd.raddr),
    .rdata_o (row_src_rdata)
  );

  rcs_ram #(.DEPTH(ROWS), .WIDTH(ROW_W)) u_row_plc (
    .clk_i   (clk_i),
    .we_i    (row_plc_cmd.we),
    .waddr_i (row_plc_cmd.waddr),
    .wdata_i (row_plc_cmd.wdata),
    .re_i    (row_plc_cmd.re),
    .raddr_i (row_plc_cmd.raddr),
    .rdata_o (row_plc_rdata)
  );

  // Column maps: original column at each current column, and its inverse.
  rcs_ram #(.DEPTH(COLS), .WIDTH(COL_W)) u_col_src (
    .clk_i   (clk_i),
    .we_i    (col_src_cmd.we),
    .waddr_i (col_src_cmd.waddr),
    .wdata_i (col_src_cmd.wdata),
    .re_i    (col_src_cmd.re),
    .raddr_i (col_src_cmd.raddr),
    .rdata_o (col_src_rdata)
  );

  rcs_ram #(.DEPTH(COLS), .WIDTH(COL_W)) u_col_plc (
    .clk_i   (clk_i),
    .we_i    (col_plc_cmd.we),
    .waddr_i (col_plc_cmd.waddr),
    .wdata_i (col_plc_cmd.wdata),
    .re_i    (col_plc_cmd.re),
    .raddr_i (col_plc_cmd.raddr),
    .rdata_o (col_plc_rdata)
  );

  // Output register on the result channel.
  rcs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_row_column_swap_cell_map.sv
// Self-checking testbench of the row/column swap cell map, with its own predictor of the grid.
`timescale 1ns / 1ps
module tb_row_column_swap_cell_map;
  import rcs_pkg::*;

  localparam int unsigned IDX_MAX        = (1 << IDX_W) - 1;
  localparam int unsigned CELL_MAX       = (1 << CELL_W) - 1;
  localparam int unsigned GRID_CELLS     = ROWS * COLS;
  localparam int unsigned RANDOM_ITEMS   = 1250;
  // Covers the clearing pass after reset plus the longest stall on either side, many times.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 16;

  // Tracks the row and column permutations and the answers they imply.
  class cell_map_tracker;
    int unsigned row_src[ROWS];
    int unsigned row_pl[ROWS];
    int unsigned col_src[COLS];
    int unsigned col_pl[COLS];
    rsp_t        pending_answers[$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < ROWS; i++) begin
        row_src[i] = i;
        row_pl[i]  = i;
      end
      for (int i = 0; i < COLS; i++) begin
        col_src[i] = i;
        col_pl[i]  = i;
      end
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return pending_answers.size();
    endfunction

    // Applies one accepted request and queues the answer it must produce, if any.
    function void note_request(req_e kind, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                               logic [CELL_W-1:0] n);
      rsp_t        ans;
      int unsigned ia;
      int unsigned ib;
      int unsigned cn;
      int unsigned held;
      int unsigned n0;
      ia  = a;
      ib  = b;
      cn  = n;
      ans = '0;
      case (kind)
        REQ_SWAP_ROW: begin
          if (ia < 1 || ia > ROWS || ib < 1 || ib > ROWS) begin
            ans.status      = STATUS_ERR;
            ans.result_kind = KIND_QUERY;
            pending_answers.push_back(ans);
          end else begin
            held             = row_src[ia-1];
            row_src[ia-1]    = row_src[ib-1];
            row_src[ib-1]    = held;
            row_pl[row_src[ia-1]] = ia - 1;
            row_pl[row_src[ib-1]] = ib - 1;
          end
        end
        REQ_SWAP_COL: begin
          if (ia < 1 || ia > COLS || ib < 1 || ib > COLS) begin
            ans.status      = STATUS_ERR;
            ans.result_kind = KIND_QUERY;
            pending_answers.push_back(ans);
          end else begin
            held             = col_src[ia-1];
            col_src[ia-1]    = col_src[ib-1];
            col_src[ib-1]    = held;
            col_pl[col_src[ia-1]] = ia - 1;
            col_pl[col_src[ib-1]] = ib - 1;
          end
        end
        REQ_QUERY: begin
          ans.result_kind = KIND_QUERY;
          if (ia < 1 || ia > ROWS || ib < 1 || ib > COLS) begin
            ans.status = STATUS_ERR;
          end else begin
            ans.status     = STATUS_OK;
            ans.cell_value = CELL_W'(row_src[ia-1] * COLS + col_src[ib-1] + 1);
          end
          pending_answers.push_back(ans);
        end
        default: begin
          ans.result_kind = KIND_LOCATE;
          if (cn < 1 || cn > GRID_CELLS) begin
            ans.status = STATUS_ERR;
          end else begin
            n0               = cn - 1;
            ans.status       = STATUS_OK;
            ans.row_position = ROWP_W'(row_pl[n0 / COLS] + 1);
            ans.col_position = COLP_W'(col_pl[n0 % COLS] + 1);
          end
          pending_answers.push_back(ans);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    // Compares one accepted result with the oldest queued answer.
    function void check_result(rsp_t seen);
      rsp_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d kind %0d cell %0d",
                 $time, seen.status, seen.result_kind, seen.cell_value);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("status", want.status, seen.status);
      compare_field("result_kind", want.result_kind, seen.result_kind);
      compare_field("cell_value", want.cell_value, seen.cell_value);
      compare_field("row_position", want.row_position, seen.row_position);
      compare_field("col_position", want.col_position, seen.col_position);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rcs_req_if req_bus ();
  rcs_rsp_if rsp_bus ();

  cell_map_tracker tracker;
  int unsigned     burst_left;
  int unsigned     idle_cycles;

  row_column_swap_cell_map dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Clock with a 10 ns period.
  always #5 clk_i = ~clk_i;

  // Observe both channels: check results first, then record newly accepted requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        tracker.check_result({rsp_bus.status, rsp_bus.result_kind, rsp_bus.cell_value,
                              rsp_bus.row_position, rsp_bus.col_position});
      end
      if (req_bus.valid && req_bus.ready) begin
        tracker.note_request(req_e'(req_bus.req_type), req_bus.index_a, req_bus.index_b,
                             req_bus.cell_number);
      end
    end
  end

  // Ends the run if no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The result side stalls in phases: always ready, mostly ready, mostly stalled, long stalls.
  initial begin : result_stall
    int unsigned mode;
    int unsigned span;
    int unsigned hold_low;
    rsp_bus.ready = 1'b0;
    hold_low      = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (hold_low != 0) begin
              rsp_bus.ready <= 1'b0;
              hold_low--;
            end else begin
              rsp_bus.ready <= 1'b1;
              if ($urandom_range(0, 7) == 0) hold_low = $urandom_range(5, 30);
            end
          end
        endcase
      end
    end
  end

  // Presents one request item and waits until it is accepted; valid stays high.
  task automatic send_item(req_e kind, int unsigned a, int unsigned b, int unsigned n);
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= kind;
    req_bus.index_a     <= a[IDX_W-1:0];
    req_bus.index_b     <= b[IDX_W-1:0];
    req_bus.cell_number <= n[CELL_W-1:0];
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // Sends one item, then idles between bursts of random length.
  task automatic offer(req_e kind, int unsigned a, int unsigned b, int unsigned n);
    int unsigned gap;
    send_item(kind, a, b, n);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 15);
    end else begin
      burst_left--;
    end
  endtask

  // Stops sending until every queued answer has been returned.
  task automatic drain_answers();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  // Mostly small indices so that swaps and lookups keep meeting each other.
  function automatic int unsigned pick_index(int unsigned span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(1, (span < 8) ? span : 8);
      5, 6, 7:       return $urandom_range(1, span);
      8:             return span;
      default:       return 1;
    endcase
  endfunction

  function automatic int unsigned bad_index(int unsigned span);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return $urandom_range(span + 1, IDX_MAX);
      default: return IDX_MAX;
    endcase
  endfunction

  // Main stimulus: directed corner items, then random traffic.
  initial begin : stimulus
    int unsigned sel;
    int unsigned a;
    int unsigned b;
    int unsigned n;
    tracker             = new();
    burst_left          = 0;
    idle_cycles         = 0;
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_SWAP_ROW;
    req_bus.index_a     = '0;
    req_bus.index_b     = '0;
    req_bus.cell_number = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corners of the identity grid.
    offer(REQ_QUERY, 1, 1, 0);
    offer(REQ_QUERY, ROWS, COLS, CELL_MAX);
    offer(REQ_LOCATE, 0, 0, 1);
    offer(REQ_LOCATE, IDX_MAX, IDX_MAX, GRID_CELLS);
    // Swap the outermost rows and columns, then look again.
    offer(REQ_SWAP_ROW, 1, ROWS, 0);
    offer(REQ_SWAP_COL, 1, COLS, CELL_MAX);
    offer(REQ_QUERY, 1, 1, 0);
    offer(REQ_LOCATE, 0, 0, 1);
    offer(REQ_LOCATE, 0, 0, GRID_CELLS);
    // A swap of an index with itself leaves the maps alone.
    offer(REQ_SWAP_ROW, 5, 5, 0);
    offer(REQ_SWAP_COL, 7, 7, 0);
    offer(REQ_QUERY, 5, 7, 0);
    // Out-of-range swaps, queries and locates.
    offer(REQ_SWAP_ROW, 0, 3, 0);
    offer(REQ_SWAP_ROW, 3, ROWS + 1, 0);
    offer(REQ_SWAP_COL, 0, 2, 0);
    offer(REQ_SWAP_COL, 2, COLS + 1, 0);
    offer(REQ_QUERY, 0, 1, 0);
    offer(REQ_QUERY, ROWS + 1, 1, 0);
    offer(REQ_QUERY, 1, 0, 0);
    offer(REQ_QUERY, 1, COLS + 1, 0);
    offer(REQ_LOCATE, 0, 0, 0);
    offer(REQ_LOCATE, 0, 0, GRID_CELLS + 1);
    // All-ones fields on row swap, query and locate requests.
    offer(REQ_SWAP_ROW, IDX_MAX, IDX_MAX, CELL_MAX);
    offer(REQ_QUERY, IDX_MAX, IDX_MAX, CELL_MAX);
    offer(REQ_LOCATE, IDX_MAX, IDX_MAX, CELL_MAX);
    drain_answers();

    // Random traffic, mostly well-formed, with a full drain part way through.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_answers();
      sel = $urandom_range(0, 99);
      n   = $urandom_range(0, CELL_MAX);
      if (sel < 30) begin
        offer(REQ_SWAP_ROW, pick_index(ROWS), pick_index(ROWS), n);
      end else if (sel < 50) begin
        offer(REQ_SWAP_COL, pick_index(COLS), pick_index(COLS), n);
      end else if (sel < 70) begin
        offer(REQ_QUERY, pick_index(ROWS), pick_index(COLS), n);
      end else if (sel < 90) begin
        n = (pick_index(ROWS) - 1) * COLS + pick_index(COLS);
        offer(REQ_LOCATE, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX), n);
      end else begin
        // One field out of range.
        case ($urandom_range(0, 3))
          0: begin
            a = bad_index(ROWS);
            b = pick_index(ROWS);
            if ($urandom_range(0, 1) != 0) offer(REQ_SWAP_ROW, a, b, n);
            else offer(REQ_SWAP_ROW, b, a, n);
          end
          1: begin
            a = bad_index(COLS);
            b = pick_index(COLS);
            if ($urandom_range(0, 1) != 0) offer(REQ_SWAP_COL, a, b, n);
            else offer(REQ_SWAP_COL, b, a, n);
          end
          2: begin
            if ($urandom_range(0, 1) != 0) offer(REQ_QUERY, bad_index(ROWS), pick_index(COLS), n);
            else offer(REQ_QUERY, pick_index(ROWS), bad_index(COLS), n);
          end
          default: begin
            n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(GRID_CELLS + 1, CELL_MAX);
            offer(REQ_LOCATE, $urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX), n);
          end
        endcase
      end
    end

    // Wait for the last answers, then let the block settle.
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rcs_pkg.sv
hdl/rcs_req_if.sv
hdl/rcs_rsp_if.sv
hdl/rcs_ram.sv
hdl/rcs_seq.sv
hdl/rcs_out_reg.sv
hdl/row_column_swap_cell_map.sv
tb/tb_row_column_swap_cell_map.sv
